@@ design/adsr_pkg.sv @@
// Shared types, codes and a helper function of the ADSR envelope generator.
package adsr_pkg;

  localparam int unsigned COEFF_W = 16;
  localparam int unsigned STAGE_W = 3;
  localparam int unsigned CFG_IDX_W = 2;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_ATTACK_STEP   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DECAY_COEFF   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SUSTAIN_LEVEL = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_RELEASE_COEFF = 2'd3;

  // Stage codes as they appear on the result port.
  localparam logic [STAGE_W-1:0] STAGE_IDLE    = 3'd0;
  localparam logic [STAGE_W-1:0] STAGE_ATTACK  = 3'd1;
  localparam logic [STAGE_W-1:0] STAGE_DECAY   = 3'd2;
  localparam logic [STAGE_W-1:0] STAGE_SUSTAIN = 3'd3;
  localparam logic [STAGE_W-1:0] STAGE_RELEASE = 3'd4;
  localparam logic [STAGE_W-1:0] STAGE_DONE    = 3'd5;

  typedef enum logic [5:0] {
    ST_IDLE    = 6'b000001,
    ST_ATTACK  = 6'b000010,
    ST_DECAY   = 6'b000100,
    ST_SUSTAIN = 6'b001000,
    ST_RELEASE = 6'b010000,
    ST_DONE    = 6'b100000
  } stage_e;

  function automatic logic [STAGE_W-1:0] stage_code(stage_e s);
    logic [STAGE_W-1:0] code;
    unique case (s)
      ST_IDLE:    code = STAGE_IDLE;
      ST_ATTACK:  code = STAGE_ATTACK;
      ST_DECAY:   code = STAGE_DECAY;
      ST_SUSTAIN: code = STAGE_SUSTAIN;
      ST_RELEASE: code = STAGE_RELEASE;
      ST_DONE:    code = STAGE_DONE;
      default:    code = STAGE_IDLE;
    endcase
    return code;
  endfunction

endpackage

@@ design/adsr_envelope_generator_unit.sv @@
// A tick accepted into the input register goes to the result register once that is free or
// is being emptied. Throughput: one tick per cycle while the result side does not stall; the
// envelope state loop closes through one shared multiplier with its add and compare.
// Reset: asynchronous, active low; the envelope returns to idle with level zero and
// inactive, the configuration registers take their documented defaults, and both
// the input and the result register are emptied.
module adsr_envelope_generator_unit #(
  parameter int unsigned LEVEL_FRAC_BITS = 16
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // Tick input channel.
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic                           start_trigger_i,
  input  logic                           release_trigger_i,
  // Result channel.
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic [LEVEL_FRAC_BITS:0]       env_level_o,
  output logic [adsr_pkg::STAGE_W-1:0]   env_stage_o,
  output logic                           voice_active_o,
  output logic                           sounding_o,
  // Configuration write channel.
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [adsr_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [((LEVEL_FRAC_BITS + 1 > 16) ? LEVEL_FRAC_BITS : 15):0] cfg_data_i
);
  import adsr_pkg::*;

  localparam int unsigned LevelW = LEVEL_FRAC_BITS + 1;
  localparam int unsigned CfgW = (LevelW > COEFF_W) ? LevelW : COEFF_W;

  logic [LevelW-1:0]  attack_step, sustain_level;
  logic [COEFF_W-1:0] decay_coeff, release_coeff;

  // Input register: holds one tick transaction until the core evaluates it.
  logic in_valid_q, start_q, release_q;
  // Result register.
  logic               out_valid_q;
  logic [LevelW-1:0]  level_q;
  logic [STAGE_W-1:0] stage_q;
  logic               active_q, sounding_q;

  logic               advance;
  logic [LevelW-1:0]  core_level;
  logic [STAGE_W-1:0] core_stage;
  logic               core_active, core_sounding;

  // The buffered tick is evaluated whenever the result register is free or is
  // being emptied in the same cycle. The state registers in the core update on
  // that same edge, so back-to-back ticks see each other's results.
  assign advance    = in_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !in_valid_q || advance;

  // Configuration writes always taken; user must keep them to idle (block does not check).
  assign cfg_ready_o = 1'b1;

  adsr_cfg_regs #(
    .LEVEL_FRAC_BITS(LEVEL_FRAC_BITS),
    .CFG_W(CfgW)
  ) u_cfg (
    .clk_i,
    .rst_ni,
    .wr_en_i        (cfg_valid_i),
    .wr_index_i     (cfg_index_i),
    .wr_data_i      (cfg_data_i),
    .attack_step_o  (attack_step),
    .decay_coeff_o  (decay_coeff),
    .sustain_level_o(sustain_level),
    .release_coeff_o(release_coeff)
  );

  adsr_core #(
    .LEVEL_FRAC_BITS(LEVEL_FRAC_BITS)
  ) u_core (
    .clk_i,
    .rst_ni,
    .advance_i      (advance),
    .start_i        (start_q),
    .release_i      (release_q),
    .attack_step_i  (attack_step),
    .decay_coeff_i  (decay_coeff),
    .sustain_level_i(sustain_level),
    .release_coeff_i(release_coeff),
    .level_o        (core_level),
    .stage_o        (core_stage),
    .active_o       (core_active),
    .sounding_o     (core_sounding)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      start_q   <= start_trigger_i;
      release_q <= release_trigger_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      level_q    <= core_level;
      stage_q    <= core_stage;
      active_q   <= core_active;
      sounding_q <= core_sounding;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign env_level_o    = level_q;
  assign env_stage_o    = stage_q;
  assign voice_active_o = active_q;
  assign sounding_o     = sounding_q;

endmodule

@@ design/adsr_cfg_regs.sv @@
// Configuration register file of the ADSR envelope generator.
module adsr_cfg_regs #(
  parameter int unsigned LEVEL_FRAC_BITS = 16,
  parameter int unsigned CFG_W = 17
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           wr_en_i,
  input  logic [adsr_pkg::CFG_IDX_W-1:0] wr_index_i,
  input  logic [CFG_W-1:0]               wr_data_i,
  output logic [LEVEL_FRAC_BITS:0]       attack_step_o,
  output logic [adsr_pkg::COEFF_W-1:0]   decay_coeff_o,
  output logic [LEVEL_FRAC_BITS:0]       sustain_level_o,
  output logic [adsr_pkg::COEFF_W-1:0]   release_coeff_o
);
  import adsr_pkg::*;

  localparam int unsigned LevelW = LEVEL_FRAC_BITS + 1;
  localparam logic [LevelW-1:0] LevelOne = {1'b1, {LEVEL_FRAC_BITS{1'b0}}};
  localparam logic [LevelW-1:0] AttackReset = LevelW'(137);
  // The sustain level is stored already saturated to one.
  localparam logic [LevelW-1:0] SustainReset =
    (LEVEL_FRAC_BITS > 16) ? LevelW'(65536) : LevelOne;

  logic [LevelW-1:0]  attack_q, sustain_q, wr_level;
  logic [COEFF_W-1:0] decay_q, release_q;

  assign wr_level = wr_data_i[LevelW-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      attack_q  <= AttackReset;
      decay_q   <= COEFF_W'(65495);
      sustain_q <= SustainReset;
      release_q <= COEFF_W'(65434);
    end else if (wr_en_i) begin
      unique case (wr_index_i)
        CFG_ATTACK_STEP:   attack_q  <= wr_level;
        CFG_DECAY_COEFF:   decay_q   <= wr_data_i[COEFF_W-1:0];
        CFG_SUSTAIN_LEVEL: sustain_q <= (wr_level > LevelOne) ? LevelOne : wr_level;
        CFG_RELEASE_COEFF: release_q <= wr_data_i[COEFF_W-1:0];
        default: ;
      endcase
    end
  end

  assign attack_step_o   = attack_q;
  assign decay_coeff_o   = decay_q;
  assign sustain_level_o = sustain_q;
  assign release_coeff_o = release_q;

endmodule

@@ design/adsr_core.sv @@
// Envelope state registers and the single-tick update datapath.
module adsr_core #(
  parameter int unsigned LEVEL_FRAC_BITS = 16
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             advance_i,
  input  logic                             start_i,
  input  logic                             release_i,
  input  logic [LEVEL_FRAC_BITS:0]         attack_step_i,
  input  logic [adsr_pkg::COEFF_W-1:0]     decay_coeff_i,
  input  logic [LEVEL_FRAC_BITS:0]         sustain_level_i,
  input  logic [adsr_pkg::COEFF_W-1:0]     release_coeff_i,
  output logic [LEVEL_FRAC_BITS:0]         level_o,
  output logic [adsr_pkg::STAGE_W-1:0]     stage_o,
  output logic                             active_o,
  output logic                             sounding_o
);
  import adsr_pkg::*;

  localparam int unsigned LevelW = LEVEL_FRAC_BITS + 1;
  localparam int unsigned ProdW = LevelW + COEFF_W;
  localparam logic [LevelW-1:0] LevelOne = {1'b1, {LEVEL_FRAC_BITS{1'b0}}};
  localparam int unsigned OneInt = 1 << LEVEL_FRAC_BITS;
  localparam logic [LevelW-1:0] DecaySnap = LevelW'((OneInt + 500) / 1000);
  localparam logic [LevelW-1:0] ReleaseSnap = LevelW'((OneInt + 5000) / 10000);

  stage_e            stage_q, stage_d, stage_s, stage_r;
  logic [LevelW-1:0] level_q, level_d, level_s;
  logic              active_q, active_d, active_s, run;

  logic [LevelW:0]    attack_sum;
  logic               diff_neg;
  logic [LevelW-1:0]  diff_mag, mul_a, scaled;
  logic [COEFF_W-1:0] mul_b;
  logic [ProdW-1:0]   prod;

  // Start is applied first, then release.
  always_comb begin
    stage_s  = start_i ? ST_ATTACK : stage_q;
    active_s = start_i | active_q;
    level_s  = start_i ? '0 : level_q;
    if (release_i && (stage_s == ST_ATTACK || stage_s == ST_DECAY || stage_s == ST_SUSTAIN)) begin
      stage_r = ST_RELEASE;
    end else begin
      stage_r = stage_s;
    end
  end

  // One multiplier serves decay (distance to sustain) and release (level).
  assign diff_neg = level_s < sustain_level_i;
  assign diff_mag = diff_neg ? (sustain_level_i - level_s) : (level_s - sustain_level_i);
  assign mul_a    = (stage_r == ST_DECAY) ? diff_mag : level_s;
  assign mul_b    = (stage_r == ST_DECAY) ? decay_coeff_i : release_coeff_i;
  assign prod     = ProdW'(mul_a) * ProdW'(mul_b);
  assign scaled   = prod[ProdW-1:COEFF_W];

  assign attack_sum = {1'b0, level_s} + {1'b0, attack_step_i};

  assign run = active_s && (stage_r == ST_ATTACK || stage_r == ST_DECAY ||
                            stage_r == ST_SUSTAIN || stage_r == ST_RELEASE);

  always_comb begin
    stage_d  = stage_r;
    level_d  = level_s;
    active_d = active_s;
    if (run) begin
      unique case (stage_r)
        ST_ATTACK: begin
          if (attack_sum >= {1'b0, LevelOne}) begin
            level_d = LevelOne;
            stage_d = ST_DECAY;
          end else begin
            level_d = attack_sum[LevelW-1:0];
          end
        end
        ST_DECAY: begin
          // Below sustain the signed step is never positive, so it always snaps.
          if (diff_neg || scaled < DecaySnap) begin
            level_d = sustain_level_i;
            stage_d = ST_SUSTAIN;
          end else begin
            level_d = sustain_level_i + scaled;
          end
        end
        ST_SUSTAIN: level_d = sustain_level_i;
        ST_RELEASE: begin
          if (scaled < ReleaseSnap) begin
            level_d  = '0;
            stage_d  = ST_DONE;
            active_d = 1'b0;
          end else begin
            level_d = scaled;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stage_q  <= ST_IDLE;
      level_q  <= '0;
      active_q <= 1'b0;
    end else if (advance_i) begin
      stage_q  <= stage_d;
      level_q  <= level_d;
      active_q <= active_d;
    end
  end

  assign level_o    = level_d;
  assign stage_o    = stage_code(stage_d);
  assign active_o   = active_d;
  assign sounding_o = run && (stage_d != ST_DONE);

endmodule

@@ bench/adsr_envelope_generator_unit_tb.sv @@
// Self-checking testbench for the ADSR envelope generator: directed corner cases, then random envelopes.
module adsr_envelope_generator_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import adsr_pkg::*;

  localparam int unsigned LFB = 16;
  localparam longint ONE = longint'(1) << LFB;
  // Snap thresholds: 0.001 and 0.0001 of full scale, rounded.
  localparam longint DECAY_SNAP = (ONE + 500) / 1000;
  localparam longint RELEASE_SNAP = (ONE + 5000) / 10000;
  localparam int RANDOM_TICKS = 400;
  localparam int SETTLE_CYCLES = 4;
  localparam int LIMIT_CYCLES = 400000;

  // One result transaction as the block should deliver it.
  typedef struct {
    logic [LFB:0]         level;
    logic [STAGE_W-1:0]   stage;
    logic                 active;
    logic                 sounding;
  } envelope_tick_t;

  logic                 clk_i;
  logic                 rst_ni = 1'b0;
  logic                 in_valid_i = 1'b0;
  logic                 in_ready_o;
  logic                 start_trigger_i = 1'b0;
  logic                 release_trigger_i = 1'b0;
  logic                 out_valid_o;
  logic                 out_ready_i = 1'b0;
  logic [LFB:0]         env_level_o;
  logic [STAGE_W-1:0]   env_stage_o;
  logic                 voice_active_o;
  logic                 sounding_o;
  logic                 cfg_valid_i = 1'b0;
  logic                 cfg_ready_o;
  logic [CFG_IDX_W-1:0] cfg_index_i = CFG_ATTACK_STEP;
  logic [LFB:0]         cfg_data_i = '0;

  adsr_envelope_generator_unit #(
    .LEVEL_FRAC_BITS(LFB)
  ) dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .start_trigger_i  (start_trigger_i),
    .release_trigger_i(release_trigger_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .env_level_o      (env_level_o),
    .env_stage_o      (env_stage_o),
    .voice_active_o   (voice_active_o),
    .sounding_o       (sounding_o),
    .cfg_valid_i      (cfg_valid_i),
    .cfg_ready_o      (cfg_ready_o),
    .cfg_index_i      (cfg_index_i),
    .cfg_data_i       (cfg_data_i)
  );

  // Shadow copy of the configuration registers, starting at their reset values.
  longint reg_attack_step = 137;
  longint reg_decay_coeff = 65495;
  longint reg_sustain_level = 65536;
  longint reg_release_coeff = 65434;

  // Shadow copy of the envelope state.
  logic [STAGE_W-1:0] track_stage = STAGE_IDLE;
  longint             track_level = 0;
  logic               track_active = 1'b0;

  // Envelope ticks accepted by the block whose results have not come back yet.
  envelope_tick_t pending_ticks[$];

  int mismatches = 0;
  int ticks_sent = 0;
  int burst_left = 0;
  int cycle_count = 0;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Watchdog: a correct run finishes far below this many cycles.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // Q0.16 scaling of a nonnegative magnitude, truncated toward zero.
  function automatic longint scale_q16(longint mag, longint coeff);
    return (mag * coeff) >> 16;
  endfunction

  // Advances the shadow envelope by one sample tick and returns the result it should produce.
  function automatic envelope_tick_t step_envelope(logic start, logic rel);
    envelope_tick_t r;
    longint sus;
    longint diff;
    longint d;
    logic   sounding;
    sus = (reg_sustain_level > ONE) ? ONE : reg_sustain_level;
    sounding = 1'b0;
    // A start trigger takes effect first, so start and release together end up in release.
    if (start) begin
      track_active = 1'b1;
      track_stage = STAGE_ATTACK;
      track_level = 0;
    end
    if (rel && (track_stage == STAGE_ATTACK || track_stage == STAGE_DECAY ||
                track_stage == STAGE_SUSTAIN)) begin
      track_stage = STAGE_RELEASE;
    end
    if (track_active && track_stage >= STAGE_ATTACK && track_stage <= STAGE_RELEASE) begin
      case (track_stage)
        STAGE_ATTACK: begin
          track_level += reg_attack_step;
          if (track_level >= ONE) begin
            track_level = ONE;
            track_stage = STAGE_DECAY;
          end
        end
        STAGE_DECAY: begin
          // The distance to sustain shrinks by the coefficient; a level below
          // sustain gives a negative step, which always snaps.
          diff = track_level - sus;
          d = (diff >= 0) ? scale_q16(diff, reg_decay_coeff) : -scale_q16(-diff, reg_decay_coeff);
          track_level = sus + d;
          if (d < DECAY_SNAP) begin
            track_level = sus;
            track_stage = STAGE_SUSTAIN;
          end
        end
        STAGE_SUSTAIN: begin
          track_level = sus;
        end
        default: begin
          track_level = scale_q16(track_level, reg_release_coeff);
          if (track_level < RELEASE_SNAP) begin
            track_level = 0;
            track_stage = STAGE_DONE;
            track_active = 1'b0;
          end
        end
      endcase
      sounding = (track_stage != STAGE_DONE);
    end
    r.level = track_level[LFB:0];
    r.stage = track_stage;
    r.active = track_active;
    r.sounding = sounding;
    return r;
  endfunction

  function automatic void check_field(string field, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      $display("%0t ns: %s mismatch, expected %0d, got %0d", $time, field, want, got);
      mismatches++;
    end
  endfunction

  // Every result transaction is matched against the oldest pending tick. Sampling
  // happens at the rising edge, before the block's registers update.
  always @(posedge clk_i) begin
    envelope_tick_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_ticks.size() == 0) begin
        $display("%0t ns: result with no tick pending, expected nothing, got level %0d stage %0d",
                 $time, env_level_o, env_stage_o);
        mismatches++;
      end else begin
        want = pending_ticks.pop_front();
        check_field("env_level", 32'(want.level), 32'(env_level_o));
        check_field("env_stage", 32'(want.stage), 32'(env_stage_o));
        check_field("voice_active", 32'(want.active), 32'(voice_active_o));
        check_field("sounding", 32'(want.sounding), 32'(sounding_o));
      end
    end
  end

  // The result side stalls on a pattern of its own: stretches of always-ready,
  // coin-flip readiness, and mostly-stalled, each of random length.
  int ready_mode = 0;
  int ready_left = 0;
  always @(negedge clk_i) begin
    if (ready_left == 0) begin
      ready_mode = $urandom_range(0, 2);
      ready_left = $urandom_range(8, 60);
    end
    ready_left--;
    case (ready_mode)
      0:       out_ready_i <= 1'b1;
      1:       out_ready_i <= ($urandom_range(0, 1) == 0);
      default: out_ready_i <= ($urandom_range(0, 3) == 0);
    endcase
  end

  // Sends one tick transaction. It is entered and left just after a falling edge.
  // The sender works in bursts; a new burst may be preceded by a random gap.
  task automatic send_tick(input logic start, input logic rel);
    int gap;
    envelope_tick_t expected;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
    end
    burst_left--;
    in_valid_i <= 1'b1;
    start_trigger_i <= start;
    release_trigger_i <= rel;
    do @(posedge clk_i); while (!in_ready_o);
    expected = step_envelope(start, rel);
    pending_ticks = {pending_ticks, expected};
    ticks_sent++;
    @(negedge clk_i);
  endtask

  // Stops the sender and waits until every pending result has come back, then a
  // settling wait, so that the block is idle afterwards.
  task automatic drain_envelopes();
    in_valid_i <= 1'b0;
    @(negedge clk_i);
    while (pending_ticks.size() != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  // Writes one configuration register; only called while the block is idle.
  task automatic write_register(input logic [CFG_IDX_W-1:0] idx, input longint value);
    logic [LFB:0] data;
    data = value[LFB:0];
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      CFG_ATTACK_STEP:   reg_attack_step = longint'(data);
      CFG_DECAY_COEFF:   reg_decay_coeff = longint'(data[15:0]);
      CFG_SUSTAIN_LEVEL: reg_sustain_level = longint'(data);
      default:           reg_release_coeff = longint'(data[15:0]);
    endcase
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
    @(negedge clk_i);
  endtask

  function automatic longint pick_coeff();
    case ($urandom_range(0, 9))
      0:       return 0;
      1:       return 65535;
      default: return $urandom_range(0, 58000);
    endcase
  endfunction

  // Random setting; most draws keep envelopes short enough to run to completion.
  task automatic write_random_setting();
    longint attack;
    longint sustain;
    case ($urandom_range(0, 11))
      0:       attack = 1;
      1:       attack = ONE;
      2:       attack = $urandom_range(ONE + 1, 2 * ONE - 1);
      default: attack = $urandom_range(1500, ONE - 1);
    endcase
    case ($urandom_range(0, 9))
      0:       sustain = 0;
      1:       sustain = ONE;
      2:       sustain = $urandom_range(ONE + 1, 2 * ONE - 1);
      default: sustain = $urandom_range(0, ONE - 1);
    endcase
    write_register(CFG_ATTACK_STEP, attack);
    write_register(CFG_DECAY_COEFF, pick_coeff());
    write_register(CFG_SUSTAIN_LEVEL, sustain);
    write_register(CFG_RELEASE_COEFF, pick_coeff());
  endtask

  // Ticks while idle do nothing, and a release trigger while idle is ignored.
  task automatic test_idle_ticks();
    send_tick(1'b0, 1'b0);
    send_tick(1'b0, 1'b1);
  endtask

  // A full-scale attack step reaches one at once; sustain above one saturates;
  // zero coefficients snap decay on the next tick and end release on the release tick;
  // ticks in done hold, a release trigger there is ignored, and a start there restarts attack.
  task automatic test_attack_saturation();
    drain_envelopes();
    write_register(CFG_ATTACK_STEP, ONE);
    write_register(CFG_DECAY_COEFF, 0);
    write_register(CFG_SUSTAIN_LEVEL, 2 * ONE - 1);
    write_register(CFG_RELEASE_COEFF, 0);
    send_tick(1'b1, 1'b0);
    send_tick(1'b0, 1'b0);
    send_tick(1'b0, 1'b0);
    send_tick(1'b0, 1'b1);
    send_tick(1'b0, 1'b0);
    send_tick(1'b0, 1'b1);
    send_tick(1'b1, 1'b0);
  endtask

  // Start and release on the same tick, a zero attack step that never rises,
  // and an attack step wider than full scale.
  task automatic test_trigger_corners();
    drain_envelopes();
    write_register(CFG_ATTACK_STEP, 0);
    write_register(CFG_RELEASE_COEFF, 65535);
    send_tick(1'b1, 1'b1);
    send_tick(1'b1, 1'b0);
    send_tick(1'b0, 1'b0);
    send_tick(1'b0, 1'b1);
    drain_envelopes();
    write_register(CFG_ATTACK_STEP, 2 * ONE - 1);
    send_tick(1'b1, 1'b0);
    send_tick(1'b0, 1'b0);
  endtask

  // The sustain level moves while decay is under way: once to just below the
  // level, and once above it, and both times decay snaps on the next tick.
  task automatic test_sustain_retarget();
    drain_envelopes();
    write_register(CFG_ATTACK_STEP, ONE);
    write_register(CFG_DECAY_COEFF, 65535);
    write_register(CFG_SUSTAIN_LEVEL, 0);
    send_tick(1'b1, 1'b0);
    send_tick(1'b0, 1'b0);
    drain_envelopes();
    write_register(CFG_SUSTAIN_LEVEL, ONE - 36);
    send_tick(1'b0, 1'b0);
    send_tick(1'b0, 1'b1);
    send_tick(1'b0, 1'b0);
    drain_envelopes();
    write_register(CFG_DECAY_COEFF, 32768);
    write_register(CFG_SUSTAIN_LEVEL, 0);
    send_tick(1'b1, 1'b0);
    send_tick(1'b0, 1'b0);
    drain_envelopes();
    write_register(CFG_SUSTAIN_LEVEL, ONE);
    send_tick(1'b0, 1'b0);
  endtask

  // Mostly complete notes (start, run into sustain, release, run out to done) under
  // random settings, mixed with runs of random triggers and an early release now
  // and then. Occasionally the sender holds off until every result is back.
  task automatic test_random_envelopes();
    int first;
    int cap;
    int n;
    int hold;
    int rel_point;
    first = ticks_sent;
    while (ticks_sent - first < RANDOM_TICKS) begin
      if ($urandom_range(0, 2) == 0) begin
        drain_envelopes();
        write_random_setting();
      end else if ($urandom_range(0, 7) == 0) begin
        drain_envelopes();
      end
      if ($urandom_range(0, 4) == 0) begin
        repeat ($urandom_range(4, 12)) begin
          send_tick($urandom_range(0, 3) == 0, $urandom_range(0, 2) == 0);
        end
      end else begin
        cap = $urandom_range(20, 90);
        hold = $urandom_range(0, 5);
        rel_point = ($urandom_range(0, 4) == 0) ? $urandom_range(1, 10) : cap;
        send_tick(1'b1, 1'b0);
        n = 1;
        while (n < rel_point && !(track_stage == STAGE_SUSTAIN && hold == 0)) begin
          if (track_stage == STAGE_SUSTAIN) hold--;
          send_tick(1'b0, 1'b0);
          n++;
        end
        send_tick(1'b0, 1'b1);
        while (track_stage != STAGE_DONE && n < 2 * cap) begin
          send_tick(1'b0, 1'b0);
          n++;
        end
        repeat ($urandom_range(0, 2)) send_tick(1'b0, $urandom_range(0, 1) == 0);
      end
    end
  endtask

  initial begin
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    test_idle_ticks();
    test_attack_saturation();
    test_trigger_corners();
    test_sustain_retarget();
    test_random_envelopes();
    drain_envelopes();
    repeat (10) @(negedge clk_i);
    if (mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

@@ sim.f @@
design/adsr_pkg.sv
design/adsr_cfg_regs.sv
design/adsr_core.sv
design/adsr_envelope_generator_unit.sv
bench/adsr_envelope_generator_unit_tb.sv
